// File: rtl/odo_pkg.sv
`default_nettype none
package odo_pkg;

    // configuration register indexes
    localparam logic [7:0] REG_BASE_SPEED    = 8'd0;
    localparam logic [7:0] REG_CM_PER_TICK   = 8'd1;
    localparam logic [7:0] REG_INV_WHEELBASE = 8'd2;
    localparam logic [7:0] REG_START_HEADING = 8'd3;

    // reset values of the configuration registers
    localparam logic [6:0]  BASE_SPEED_RST    = 7'd70;
    localparam logic [15:0] CM_PER_TICK_RST   = 16'd5434;
    localparam logic [15:0] INV_WHEELBASE_RST = 16'd2913;
    localparam logic [31:0] START_HEADING_RST = 32'h4000_0000;

    // datapath widths
    localparam int CORDIC_W = 62;
    localparam int ANGLE_W  = 34;

    // fixed-point constants
    localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN_Q30 = 62'sd652032874;
    localparam logic signed [63:0] INV_TWO_PI_Q48 = 64'sh0000_28BE_60DB_9391;
    localparam logic signed [63:0] TWO_PI_Q29     = 64'sd3373259426;

    // arctangent of 2^-i as a binary angle
    localparam logic [31:0] ATAN_TAB [32] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81,
        32'd41,        32'd20,        32'd10,        32'd5,
        32'd3,         32'd1,         32'd1,         32'd0
    };

    // request to the CORDIC unit
    typedef struct packed {
        logic start;
        logic vector_mode;
    } cordic_req_t;

endpackage
`default_nettype wire

// File: rtl/odometry_and_target_steering.sv
// Differential-drive odometry with steering toward a target point. Each input
// transfer carries cumulative left/right encoder counts and a target; the block
// returns one result transfer with the new pose, the heading error against the
// target bearing, and two saturated drive values. Work is done by one shared
// CORDIC engine (bearing by vectoring, then sine/cosine of the old heading) and
// one shared 64x16 multiplier that runs eight products in turn; the bearing step
// is skipped when the target sits on the current position. s_tready is high only
// while the sequencer is idle; one finished result can wait in the output
// register while the next item is accepted, and the sequencer holds before the
// output while that result still waits. Configuration is accepted only while the
// sequencer is idle. Writing start_heading also loads the heading.
`default_nettype none
module odometry_and_target_steering #(
    parameter int CORDIC_STEPS = 24
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    // slave stream, tdata: left_ticks, right_ticks, target_x, target_y
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [127:0] s_tdata,
    // master stream, tdata: pose_x, pose_y, pose_heading, heading_error,
    // first_drive, second_drive, 4 zero bits
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [151:0]      m_tdata,
    // configuration write channel
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [7:0]   cfg_index,
    input  wire logic [31:0]  cfg_data
);

    typedef enum logic [2:0] {
        S_IDLE, S_BEAR, S_BEAR_WAIT, S_SINCOS, S_SC_WAIT, S_MUL, S_MUL_WAIT, S_OUT
    } state_t;

    typedef enum logic [2:0] {
        OP_SUM, OP_DIFF, OP_SCALE, OP_PX, OP_PY, OP_HEAD, OP_SPEED, OP_TERM
    } mop_t;

    localparam int CW = odo_pkg::CORDIC_W;
    localparam int AW = odo_pkg::ANGLE_W;

    state_t state_reg;
    mop_t   mop_reg;

    // configuration
    logic [6:0]  speed_reg;
    logic [15:0] cm_reg;
    logic [15:0] iwb_reg;

    // odometry state
    logic [31:0] last_l_reg, last_r_reg;
    logic [31:0] pos_x_reg, pos_y_reg, head_reg;

    // per-item work registers
    logic signed [31:0] tx_reg, ty_reg;
    logic signed [33:0] sum_reg, diff_reg;
    logic [31:0]        bear_reg;
    logic signed [31:0] cos_reg, sin_reg;
    logic signed [49:0] m1_reg, m2_reg;
    logic [61:0]        scale_reg;
    logic signed [39:0] sp_reg;
    logic signed [11:0] term_reg;

    // output register
    logic         m_tvalid_reg;
    logic [151:0] m_tdata_reg;

    // datapath nets
    logic signed [32:0] dl, dr;
    logic signed [32:0] dx, dy;
    logic signed [32:0] err;
    logic [31:0]        err_code;
    logic               flip;
    logic [31:0]        h_rot;
    logic signed [11:0] drv_p, drv_m;
    logic signed [9:0]  first_drive, second_drive;

    odo_pkg::cordic_req_t       creq;
    logic signed [CW-1:0]       cx0, cy0, cx, cy;
    logic signed [AW-1:0]       cz0, cz;
    logic                       cdone;

    logic                       mstart;
    logic signed [63:0]         ma, mb;
    logic [5:0]                 mshamt;
    logic                       mdone;
    logic [63:0]                mres;

    function automatic logic h_add_bit(input logic [31:0] h);
        logic [31:0] t;
        t = h + 32'h4000_0000;
        return t[31];
    endfunction

    // input deltas and target offset
    always_comb
    begin
        dl       = $signed({s_tdata[31], s_tdata[31:0]}) - $signed({last_l_reg[31], last_l_reg});
        dr       = $signed({s_tdata[63], s_tdata[63:32]}) - $signed({last_r_reg[31], last_r_reg});
        dx       = $signed({tx_reg[31], tx_reg}) - $signed({pos_x_reg[31], pos_x_reg});
        dy       = $signed({ty_reg[31], ty_reg}) - $signed({pos_y_reg[31], pos_y_reg});
        flip     = h_add_bit(head_reg);
        h_rot    = flip ? (head_reg + 32'h8000_0000) : head_reg;
        err_code = head_reg - bear_reg;
        err      = (err_code == 32'h8000_0000) ? 33'sh0_8000_0000
                                               : $signed({err_code[31], err_code});
    end

    // CORDIC setup
    always_comb
    begin
        creq.start       = 1'b0;
        creq.vector_mode = 1'b0;
        cx0              = '0;
        cy0              = '0;
        cz0              = '0;
        if (state_reg == S_BEAR)
        begin
            creq.start       = (dx != 33'sd0) || (dy != 33'sd0);
            creq.vector_mode = 1'b1;
            if (dx[32])
            begin
                cx0 = -(CW'(dx) <<< 24);
                cy0 = -(CW'(dy) <<< 24);
                cz0 = AW'(34'h0_8000_0000);
            end
            else
            begin
                cx0 = CW'(dx) <<< 24;
                cy0 = CW'(dy) <<< 24;
            end
        end
        else if (state_reg == S_SINCOS)
        begin
            creq.start = 1'b1;
            cx0        = odo_pkg::CORDIC_GAIN_Q30;
            cz0        = AW'($signed(h_rot));
        end
    end

    odo_cordic #(
        .STEPS (CORDIC_STEPS)
    ) u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (creq),
        .x0    (cx0),
        .y0    (cy0),
        .z0    (cz0),
        .done  (cdone),
        .x     (cx),
        .y     (cy),
        .z     (cz)
    );

    // multiplier operand selection
    always_comb
    begin
        mstart = (state_reg == S_MUL);
        ma     = '0;
        mb     = '0;
        mshamt = 6'd0;
        unique case (mop_reg)
            OP_SUM:   begin ma = 64'(sum_reg);  mb = 64'(cm_reg); end
            OP_DIFF:  begin ma = 64'(diff_reg); mb = 64'(cm_reg); end
            OP_SCALE: begin ma = 64'(iwb_reg);  mb = odo_pkg::INV_TWO_PI_Q48; end
            OP_PX:    begin ma = 64'(m1_reg);   mb = 64'(cos_reg); mshamt = 6'd39; end
            OP_PY:    begin ma = 64'(m1_reg);   mb = 64'(sin_reg); mshamt = 6'd39; end
            OP_HEAD:  begin ma = 64'(m2_reg);   mb = $signed({2'b00, scale_reg});
                            mshamt = 6'd48; end
            OP_SPEED: begin ma = $signed({57'd0, speed_reg}); mb = 64'(err); end
            OP_TERM:  begin ma = 64'(sp_reg);   mb = odo_pkg::TWO_PI_Q29; mshamt = 6'd61; end
            default:  begin ma = '0; mb = '0; end
        endcase
    end

    odo_mul u_mul (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mstart),
        .a      (ma),
        .b      (mb),
        .shamt  (mshamt),
        .done   (mdone),
        .result (mres)
    );

    // drive values with saturation
    always_comb
    begin
        drv_p = $signed({5'd0, speed_reg}) + term_reg;
        drv_m = $signed({5'd0, speed_reg}) - term_reg;
        if (drv_p > 12'sd511)
            first_drive = 10'sd511;
        else if (drv_p < -12'sd512)
            first_drive = -10'sd512;
        else
            first_drive = drv_p[9:0];
        if (drv_m > 12'sd511)
            second_drive = 10'sd511;
        else if (drv_m < -12'sd512)
            second_drive = -10'sd512;
        else
            second_drive = drv_m[9:0];
    end

    // sequencer, state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            mop_reg      <= OP_SUM;
            speed_reg    <= odo_pkg::BASE_SPEED_RST;
            cm_reg       <= odo_pkg::CM_PER_TICK_RST;
            iwb_reg      <= odo_pkg::INV_WHEELBASE_RST;
            head_reg     <= odo_pkg::START_HEADING_RST;
            last_l_reg   <= '0;
            last_r_reg   <= '0;
            pos_x_reg    <= '0;
            pos_y_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            // a new result in S_OUT takes precedence over the clear
            if (m_tvalid_reg && m_tready && (state_reg != S_OUT))
            begin
                m_tvalid_reg <= 1'b0;
            end

            // configuration transfer
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    odo_pkg::REG_BASE_SPEED:    speed_reg <= cfg_data[6:0];
                    odo_pkg::REG_CM_PER_TICK:   cm_reg    <= cfg_data[15:0];
                    odo_pkg::REG_INV_WHEELBASE: iwb_reg   <= cfg_data[15:0];
                    odo_pkg::REG_START_HEADING: head_reg  <= cfg_data;
                    default: ;
                endcase
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        tx_reg     <= $signed(s_tdata[95:64]);
                        ty_reg     <= $signed(s_tdata[127:96]);
                        sum_reg    <= 34'(dl) + 34'(dr);
                        diff_reg   <= 34'(dr) - 34'(dl);
                        last_l_reg <= s_tdata[31:0];
                        last_r_reg <= s_tdata[63:32];
                        state_reg  <= S_BEAR;
                    end
                end
                S_BEAR:
                begin
                    if (creq.start)
                    begin
                        state_reg <= S_BEAR_WAIT;
                    end
                    else
                    begin
                        // target on the current position
                        bear_reg  <= '0;
                        state_reg <= S_SINCOS;
                    end
                end
                S_BEAR_WAIT:
                begin
                    if (cdone)
                    begin
                        bear_reg  <= cz[31:0];
                        state_reg <= S_SINCOS;
                    end
                end
                S_SINCOS:
                begin
                    state_reg <= S_SC_WAIT;
                end
                S_SC_WAIT:
                begin
                    if (cdone)
                    begin
                        cos_reg   <= flip ? 32'(-cx) : 32'(cx);
                        sin_reg   <= flip ? 32'(-cy) : 32'(cy);
                        mop_reg   <= OP_SUM;
                        state_reg <= S_MUL;
                    end
                end
                S_MUL:
                begin
                    state_reg <= S_MUL_WAIT;
                end
                S_MUL_WAIT:
                begin
                    if (mdone)
                    begin
                        state_reg <= S_MUL;
                        unique case (mop_reg)
                            OP_SUM:
                            begin
                                m1_reg  <= 50'(mres);
                                mop_reg <= OP_DIFF;
                            end
                            OP_DIFF:
                            begin
                                m2_reg  <= 50'(mres);
                                mop_reg <= OP_SCALE;
                            end
                            OP_SCALE:
                            begin
                                scale_reg <= mres[61:0];
                                mop_reg   <= OP_PX;
                            end
                            OP_PX:
                            begin
                                pos_x_reg <= pos_x_reg + mres[31:0];
                                mop_reg   <= OP_PY;
                            end
                            OP_PY:
                            begin
                                pos_y_reg <= pos_y_reg + mres[31:0];
                                mop_reg   <= OP_HEAD;
                            end
                            OP_HEAD:
                            begin
                                head_reg <= head_reg + mres[31:0];
                                mop_reg  <= OP_SPEED;
                            end
                            OP_SPEED:
                            begin
                                sp_reg  <= 40'(mres);
                                mop_reg <= OP_TERM;
                            end
                            OP_TERM:
                            begin
                                term_reg  <= 12'(mres);
                                state_reg <= S_OUT;
                            end
                            default:
                            begin
                                state_reg <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_OUT:
                begin
                    if (!m_tvalid_reg || m_tready)
                    begin
                        m_tdata_reg  <= {4'h0, second_drive, first_drive, err_code,
                                         head_reg, pos_y_reg, pos_x_reg};
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = (state_reg == S_IDLE);
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

endmodule
`default_nettype wire

// File: rtl/odo_cordic.sv
`default_nettype none
// Shared CORDIC engine: one shift/add step per cycle, rotation or vectoring.
module odo_cordic #(
    parameter int STEPS = 24
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire odo_pkg::cordic_req_t                  req,
    input  wire logic signed [odo_pkg::CORDIC_W-1:0]   x0,
    input  wire logic signed [odo_pkg::CORDIC_W-1:0]   y0,
    input  wire logic signed [odo_pkg::ANGLE_W-1:0]    z0,
    output logic                                       done,
    output logic signed [odo_pkg::CORDIC_W-1:0]        x,
    output logic signed [odo_pkg::CORDIC_W-1:0]        y,
    output logic signed [odo_pkg::ANGLE_W-1:0]         z
);

    localparam int CW = (STEPS > 1) ? $clog2(STEPS) : 1;

    logic          busy_reg;
    logic          done_reg;
    logic          vec_reg;
    logic [CW-1:0] cnt_reg;
    logic signed [odo_pkg::CORDIC_W-1:0] x_reg, y_reg;
    logic signed [odo_pkg::ANGLE_W-1:0]  z_reg;

    logic signed [odo_pkg::CORDIC_W-1:0] dx, dy;
    logic signed [odo_pkg::ANGLE_W-1:0]  atan;
    logic                                sigma;

    // one micro-rotation
    always_comb
    begin
        dx    = y_reg >>> cnt_reg;
        dy    = x_reg >>> cnt_reg;
        atan  = odo_pkg::ANGLE_W'(odo_pkg::ATAN_TAB[5'(cnt_reg)]);
        sigma = vec_reg ? y_reg[odo_pkg::CORDIC_W-1] : !z_reg[odo_pkg::ANGLE_W-1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            vec_reg  <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            // pulse after the last step
            done_reg <= !req.start && busy_reg && (cnt_reg == CW'(STEPS - 1));
            if (req.start)
            begin
                busy_reg <= 1'b1;
                vec_reg  <= req.vector_mode;
                cnt_reg  <= '0;
                x_reg    <= x0;
                y_reg    <= y0;
                z_reg    <= z0;
            end
            else if (busy_reg)
            begin
                if (sigma)
                begin
                    x_reg <= x_reg - dx;
                    y_reg <= y_reg + dy;
                    z_reg <= z_reg - atan;
                end
                else
                begin
                    x_reg <= x_reg + dx;
                    y_reg <= y_reg - dy;
                    z_reg <= z_reg + atan;
                end
                if (cnt_reg == CW'(STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                end
                else
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign x    = x_reg;
    assign y    = y_reg;
    assign z    = z_reg;

endmodule
`default_nettype wire

// File: rtl/odo_mul.sv
`default_nettype none
// Shared signed multiplier: 64 x 16 bits per cycle, then sign fix and
// round-half-up right shift. Result is the low 64 bits.
module odo_mul (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic signed [63:0] a,
    input  wire logic signed [63:0] b,
    input  wire logic [5:0]         shamt,
    output logic                    done,
    output logic [63:0]             result
);

    typedef enum logic [1:0] {M_IDLE, M_ACC, M_NEG, M_RND} mstate_t;

    mstate_t      state_reg;
    logic [1:0]   dig_reg;
    logic         done_reg;
    logic         neg_reg;
    logic [5:0]   sh_reg;
    logic [63:0]  ma_reg, mb_reg;
    logic [127:0] acc_reg;
    logic [63:0]  res_reg;

    logic [79:0]          pp;
    logic signed [127:0]  half;
    logic signed [127:0]  rnd;

    always_comb
    begin
        pp   = ma_reg * mb_reg[16*dig_reg +: 16];
        half = (sh_reg == 6'd0) ? 128'sd0 : (128'sd1 <<< (sh_reg - 6'd1));
        rnd  = ($signed(acc_reg) + half) >>> sh_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= M_IDLE;
            done_reg  <= 1'b0;
            dig_reg   <= '0;
        end
        else
        begin
            done_reg <= (state_reg == M_RND);
            unique case (state_reg)
                M_IDLE:
                begin
                    if (start)
                    begin
                        ma_reg    <= a[63] ? 64'(-a) : a;
                        mb_reg    <= b[63] ? 64'(-b) : b;
                        neg_reg   <= a[63] ^ b[63];
                        sh_reg    <= shamt;
                        acc_reg   <= '0;
                        dig_reg   <= 2'd3;
                        state_reg <= M_ACC;
                    end
                end
                // most significant digit first
                M_ACC:
                begin
                    acc_reg <= {acc_reg[111:0], 16'h0000} + 128'(pp);
                    dig_reg <= dig_reg - 2'd1;
                    if (dig_reg == 2'd0)
                    begin
                        state_reg <= M_NEG;
                    end
                end
                M_NEG:
                begin
                    if (neg_reg)
                    begin
                        acc_reg <= -acc_reg;
                    end
                    state_reg <= M_RND;
                end
                M_RND:
                begin
                    res_reg   <= rnd[63:0];
                    state_reg <= M_IDLE;
                end
                default:
                begin
                    state_reg <= M_IDLE;
                end
            endcase
        end
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule
`default_nettype wire

// File: rtl/odo_checker.sv
`default_nettype none
// Port-level checks for the odometry block.
module odo_checker (
    input wire logic         clk,
    input wire logic         rst_n,
    input wire logic         s_tvalid,
    input wire logic         s_tready,
    input wire logic         m_tvalid,
    input wire logic         m_tready,
    input wire logic [151:0] m_tdata
);

    // stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // the sequencer is busy right after taking an item
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input ready right after a transfer");

    // zero heading error gives equal drives
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[127:96] == 32'h0) |-> (m_tdata[137:128] == m_tdata[147:138]))
        else $error("drives differ at zero heading error");

    // a new result needs an item in flight: none appears while the input sits idle with no item offered
    assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid && s_tready && !s_tvalid |=> !m_tvalid)
        else $error("result without an accepted item");

endmodule

bind odometry_and_target_steering odo_checker u_odo_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
`default_nettype wire
